/* rtl/sms_pkg.sv */
// Package of shared types and constants for the substring match scanner.
package sms_pkg;

    // Register indexes on the configuration port (byte address is 8 times the index).
    localparam logic [2:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [2:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [2:0] REG_PATTERN_LENGTH = 3'd2;
    localparam logic [2:0] REG_SEARCH_MODE    = 3'd3;
    localparam logic [2:0] REG_SEARCH_LIMIT   = 3'd4;

    // Search modes.
    localparam logic [1:0] MODE_FIRST       = 2'd0;
    localparam logic [1:0] MODE_LAST        = 2'd1;
    localparam logic [1:0] MODE_WITHIN      = 2'd2;
    localparam logic [1:0] MODE_EMPTY_FOUND = 2'd3;

    // Byte that ends a text.
    localparam logic [7:0] TERMINATOR = 8'h00;

    // Fixed widths of the configuration and result fields.
    localparam int ADDR_BITS   = 6;
    localparam int DATA_BITS   = 64;
    localparam int PLEN_BITS   = 5;
    localparam int LIMIT_BITS  = 16;
    localparam int START_BITS  = 16;

    // Control handed from the top level to every cell of the history row.
    typedef struct packed {
        logic shift;   // a text byte is accepted and moves along the row
        logic clear;   // the terminator is accepted and the history empties
    } cell_ctrl_t;

endpackage

/* rtl/sms_cell.sv */
// One cell of the history row: holds one past text byte and compares the byte it sees.
module sms_cell #(
    parameter int CELL_INDEX  = 0,
    parameter int MAX_PATTERN = 16,
    parameter int LEN_BITS    = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sms_pkg::cell_ctrl_t      ctrl,
    input  logic [7:0]               byte_in,
    input  logic [MAX_PATTERN*8-1:0] pattern,
    input  logic [LEN_BITS-1:0]      eff_len,
    output logic [7:0]               byte_out,
    output logic                     hit
);

    localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [7:0]          hist_reg;
    logic [7:0]          hist_next;
    logic                in_use;
    logic [LEN_BITS-1:0] sel_full;
    logic [IDX_BITS-1:0] sel;
    logic [7:0]          expected;

    // This cell checks pattern byte (length - 1 - index) while the pattern reaches it.
    assign in_use   = eff_len > LEN_BITS'(CELL_INDEX);
    assign sel_full = eff_len - LEN_BITS'(CELL_INDEX) - LEN_BITS'(1);
    assign sel      = sel_full[IDX_BITS-1:0];
    assign expected = pattern[{sel, 3'b000} +: 8];
    assign hit      = !in_use || (byte_in == expected);

    // The stored byte moves on to the next cell on every accepted text byte.
    always_comb begin
        hist_next = hist_reg;
        if (ctrl.clear) begin
            hist_next = '0;
        end else if (ctrl.shift) begin
            hist_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else begin
            hist_reg <= hist_next;
        end
    end

    assign byte_out = hist_reg;

endmodule

/* rtl/substring_match_scanner_unit.sv */
// Top level of the substring match scanner: configuration, cell row, position and result.
// Throughput: one text byte per cycle; a zero byte is held off only while a result waits.
// The result of a text is shown on the m_ port in the cycle after its zero byte is accepted.
// The compare across the row of history cells is combinational.
// Reset (aresetn, synchronous, active low) clears the configuration and stream registers, history,
// counters and the result valid flag. The clear takes effect at once; there is no clearing pass.
module substring_match_scanner_unit #(
    parameter int MAX_PATTERN   = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sms_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [sms_pkg::DATA_BITS-1:0]  pwdata,
    output logic [sms_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    // Text byte channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_text_byte,
    // Result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_found,
    output logic [sms_pkg::START_BITS-1:0] m_match_start,
    output logic                           m_position_overflow
);

    localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);
    localparam int POS_W    = POSITION_BITS + 1;
    localparam int CMP_W    = (POS_W > sms_pkg::LIMIT_BITS) ? POS_W : sms_pkg::LIMIT_BITS;
    localparam logic [POS_W-1:0] CAP = POS_W'(1) << POSITION_BITS;

    // Configuration registers.
    logic [63:0]                       pattern_low_reg;
    logic [63:0]                       pattern_high_reg;
    logic [sms_pkg::PLEN_BITS-1:0]     pattern_length_reg;
    logic [1:0]                        search_mode_reg;
    logic [sms_pkg::LIMIT_BITS-1:0]    search_limit_reg;

    // Stream state.
    logic [POS_W-1:0]                  pos_reg, pos_next;
    logic                              have_match_reg, have_match_next;
    logic [POSITION_BITS-1:0]          rec_start_reg, rec_start_next;
    logic                              ovf_reg, ovf_next;

    // Output register.
    logic                              m_valid_reg, m_valid_next;
    logic                              m_found_reg, m_found_next;
    logic [sms_pkg::START_BITS-1:0]    m_start_reg, m_start_next;
    logic                              m_ovf_reg, m_ovf_next;

    logic                              cfg_write;
    logic [127:0]                      pattern_all;
    logic [LEN_BITS-1:0]               len_cap;
    logic [LEN_BITS-1:0]               eff_len;
    logic                              in_fire;
    logic                              is_end;
    sms_pkg::cell_ctrl_t               cell_ctrl;
    logic [7:0]                        chain_byte [MAX_PATTERN];
    logic [7:0]                        chain_tail;
    logic [MAX_PATTERN-1:0]            cell_hit;
    logic [POS_W-1:0]                  pos_plus;
    logic [POS_W-1:0]                  start_full;
    logic [CMP_W-1:0]                  pos_plus_ext;
    logic [CMP_W-1:0]                  limit_ext;
    logic [CMP_W-1:0]                  start_ext;
    logic                              hit;

    // Register writes on the access phase of the configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
            search_mode_reg    <= sms_pkg::MODE_FIRST;
            search_limit_reg   <= '0;
        end else if (cfg_write) begin
            unique case (paddr[5:3])
                sms_pkg::REG_PATTERN_LOW:    pattern_low_reg    <= pwdata;
                sms_pkg::REG_PATTERN_HIGH:   pattern_high_reg   <= pwdata;
                sms_pkg::REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[sms_pkg::PLEN_BITS-1:0];
                sms_pkg::REG_SEARCH_MODE:    search_mode_reg    <= pwdata[1:0];
                sms_pkg::REG_SEARCH_LIMIT:   search_limit_reg   <= pwdata[sms_pkg::LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[5:3])
            sms_pkg::REG_PATTERN_LOW:    prdata = pattern_low_reg;
            sms_pkg::REG_PATTERN_HIGH:   prdata = pattern_high_reg;
            sms_pkg::REG_PATTERN_LENGTH: prdata = 64'(pattern_length_reg);
            sms_pkg::REG_SEARCH_MODE:    prdata = 64'(search_mode_reg);
            sms_pkg::REG_SEARCH_LIMIT:   prdata = 64'(search_limit_reg);
            default:                     prdata = '0;
        endcase
    end

    // Effective length: the length clipped to the row, cut at the first zero pattern byte.
    assign pattern_all = {pattern_high_reg, pattern_low_reg};
    assign len_cap = (pattern_length_reg > sms_pkg::PLEN_BITS'(MAX_PATTERN))
                   ? LEN_BITS'(MAX_PATTERN) : pattern_length_reg[LEN_BITS-1:0];

    always_comb begin
        eff_len = len_cap;
        for (int i = MAX_PATTERN - 1; i >= 0; i--) begin
            if ((LEN_BITS'(i) < len_cap) && (pattern_all[8*i +: 8] == 8'h00)) begin
                eff_len = LEN_BITS'(i);
            end
        end
    end

    // Request handshake: text bytes always pass, a terminator waits for a free result slot.
    assign is_end    = s_text_byte == sms_pkg::TERMINATOR;
    assign s_ready   = !is_end || !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign cell_ctrl = '{shift: in_fire && !is_end, clear: in_fire && is_end};

    // Row of history cells; the newest byte enters at cell zero.
    assign chain_byte[0] = s_text_byte;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        if (k < MAX_PATTERN - 1) begin : g_link
            sms_cell #(
                .CELL_INDEX  (k),
                .MAX_PATTERN (MAX_PATTERN),
                .LEN_BITS    (LEN_BITS)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl),
                .byte_in  (chain_byte[k]),
                .pattern  (pattern_all[MAX_PATTERN*8-1:0]),
                .eff_len  (eff_len),
                .byte_out (chain_byte[k+1]),
                .hit      (cell_hit[k])
            );
        end else begin : g_last
            sms_cell #(
                .CELL_INDEX  (k),
                .MAX_PATTERN (MAX_PATTERN),
                .LEN_BITS    (LEN_BITS)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl),
                .byte_in  (chain_byte[k]),
                .pattern  (pattern_all[MAX_PATTERN*8-1:0]),
                .eff_len  (eff_len),
                .byte_out (chain_tail),
                .hit      (cell_hit[k])
            );
        end
    end

    // Match test for the occurrence that ends at the current byte.
    assign pos_plus     = pos_reg + POS_W'(1);
    assign start_full   = pos_plus - POS_W'(eff_len);
    assign pos_plus_ext = CMP_W'(pos_plus);
    assign limit_ext    = CMP_W'(search_limit_reg);
    assign hit = (&cell_hit) && (eff_len != '0) && (pos_plus >= POS_W'(eff_len))
              && !((search_mode_reg == sms_pkg::MODE_WITHIN) && (pos_plus_ext > limit_ext));
    assign start_ext = CMP_W'(rec_start_reg);

    // Stream state and result register.
    always_comb begin
        pos_next        = pos_reg;
        have_match_next = have_match_reg;
        rec_start_next  = rec_start_reg;
        ovf_next        = ovf_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_found_next    = m_found_reg;
        m_start_next    = m_start_reg;
        m_ovf_next      = m_ovf_reg;
        if (in_fire && is_end) begin
            m_valid_next = 1'b1;
            m_ovf_next   = ovf_reg;
            m_found_next = 1'b0;
            m_start_next = '0;
            if (eff_len == '0) begin
                if (search_mode_reg == sms_pkg::MODE_EMPTY_FOUND) begin
                    m_found_next = 1'b1;
                end else if (search_mode_reg == sms_pkg::MODE_WITHIN) begin
                    m_found_next = (pos_reg != '0) || ovf_reg;
                end
            end else if (have_match_reg) begin
                m_found_next = 1'b1;
                m_start_next = start_ext[sms_pkg::START_BITS-1:0];
            end
            pos_next        = '0;
            have_match_next = 1'b0;
            rec_start_next  = '0;
            ovf_next        = 1'b0;
        end else if (in_fire) begin
            if (pos_reg >= CAP) begin
                ovf_next = 1'b1;
            end else begin
                if (hit && ((search_mode_reg == sms_pkg::MODE_LAST) || !have_match_reg)) begin
                    have_match_next = 1'b1;
                    rec_start_next  = start_full[POSITION_BITS-1:0];
                end
                pos_next = pos_plus;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            have_match_reg <= 1'b0;
            rec_start_reg  <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            have_match_reg <= have_match_next;
            rec_start_reg  <= rec_start_next;
            ovf_reg        <= ovf_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_found_reg <= m_found_next;
        m_start_reg <= m_start_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_found             = m_found_reg;
    assign m_match_start       = m_start_reg;
    assign m_position_overflow = m_ovf_reg;

    // The position count never passes its saturation value.
    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= CAP)
        else $error("position count beyond saturation");

    // Overflow is only flagged once the count has saturated.
    a_ovf_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (pos_reg == CAP))
        else $error("overflow flagged below saturation");

    // An accepted terminator leaves the stream state and the oldest history cell empty.
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && is_end) |=> ((pos_reg == '0) && !have_match_reg && !ovf_reg
                                 && (chain_tail == '0)))
        else $error("stream state not cleared after terminator");

    // A new result only follows an accepted terminator.
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(in_fire && is_end))
        else $error("result without terminator");

    // A result that is not found carries a zero start index.
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_start_reg == '0))
        else $error("start index set without a match");

endmodule
